>>> sv/ephb_pkg.sv
`default_nettype none
package ephb_pkg;

	localparam int DAYS_DEF  = 32;
	localparam int HOURS_DEF = 24;

	localparam int TS_W   = 63;
	localparam int DAY_W  = 5;
	localparam int HOUR_W = 5;
	localparam int BIN_W  = 16;
	localparam int LOCK_W = 24;

	// Stream payload widths, rounded up to whole bytes.
	localparam int IN_W  = 80;
	localparam int OUT_W = 88;

	localparam logic [LOCK_W-1:0] LOCKOUT_RESET = LOCK_W'(100000);
	localparam logic [BIN_W-1:0]  BIN_MAX       = '1;
	localparam logic [BIN_W-1:0]  BIN_ONE       = BIN_W'(1);
	localparam logic [HOUR_W-1:0] DAY_END_HOUR  = HOUR_W'(23);

	typedef enum logic {
		OP_PULSE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EVAL,
		ST_LOOK,
		ST_CLEAR,
		ST_OUT
	} state_t;

	// Lockout check result handed from the checker to the controller.
	typedef struct packed {
		logic            accepted;
		logic [TS_W-1:0] period;
	} chk_t;

	typedef struct packed {
		logic             day_cleared;
		logic             hour_rolled;
		logic [TS_W-1:0]  pulse_period_us;
		logic [BIN_W-1:0] bin_value;
		logic             pulse_counted;
		logic             pulse_accepted;
	} res_t;

endpackage
`default_nettype wire

>>> sv/energy_pulse_hourly_binner.sv
// Meter pulse binner. Each input item is either a pulse event or a read of one
// bin, and each produces exactly one result item. A pulse is accepted when at
// least lockout_us microseconds have passed since the last accepted pulse; an
// accepted pulse with a valid wall clock increments its day-and-hour bin,
// saturating at 65535, and the first pulse of a new day (previous hour 23)
// zeroes that day's 24 bins before setting its own bin to one. The bins live
// in one single-port-write, registered-read RAM of DAYS x HOURS words. After
// reset the block runs a clearing pass over all DAYS*HOURS words of that RAM
// and holds s_tready low until it is done; configuration writes are taken
// during that pass as at any other time. An accepted item then goes through
// these steps in order: the time difference is registered and the bin read,
// the item is decided and the bin written back, and the result is loaded
// into the output register once that register is free. A midnight rollover
// adds a clearing state that writes the day's HOURS bins one at a time
// through the RAM write port. A new item is taken only after the previous
// one has been loaded, but while its result still waits in the output register.
`default_nettype none
module energy_pulse_hourly_binner #(
	parameter int DAYS  = ephb_pkg::DAYS_DEF,
	parameter int HOURS = ephb_pkg::HOURS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// timestamp_us, clock_valid, day_of_month, hour_of_day, zero fill
	input  wire logic [ephb_pkg::IN_W-1:0]     s_tdata,
	// opcode
	input  wire logic                          s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// pulse_accepted, pulse_counted, bin_value, pulse_period_us,
	// hour_rolled, day_cleared, zero fill
	output logic [ephb_pkg::OUT_W-1:0]         m_tdata,
	input  wire logic                          cfg_we,
	input  wire logic [ephb_pkg::LOCK_W-1:0]   cfg_data
);
	import ephb_pkg::*;

	localparam int DEPTH = DAYS * HOURS;
	localparam int AW    = $clog2(DEPTH);

	// Input field positions inside s_tdata.
	localparam int VALID_BIT = TS_W;
	localparam int DAY_LO    = TS_W + 1;
	localparam int HOUR_LO   = DAY_LO + DAY_W;

	state_t state_q, state_d;

	logic [AW-1:0]     init_cnt_q;
	logic [HOUR_W-1:0] clr_cnt_q;
	logic              m_tvalid_q;
	logic [TS_W-1:0]   last_time_q;
	logic [HOUR_W-1:0] prev_hour_q;
	logic              known_q;
	logic [LOCK_W-1:0] lockout_q;

	// Item fields captured at acceptance.
	op_t               op_q;
	logic [TS_W-1:0]   ts_q;
	logic              valid_q;
	logic [HOUR_W-1:0] hour_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     base_q;
	logic              rng_q;
	res_t              res_q;
	res_t              out_q;

	logic [DAY_W-1:0]  in_day;
	logic [HOUR_W-1:0] in_hour;

	chk_t              chk;
	logic [BIN_W-1:0]  rd_data;
	logic [BIN_W-1:0]  inc;

	res_t              look_res;
	logic              look_wr;
	logic              look_clr;
	logic              look_acc;
	logic              look_newhr;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [BIN_W-1:0]  ram_wdata;
	logic              ram_re;
	logic              out_load;

	assign in_day  = s_tdata[DAY_LO +: DAY_W];
	assign in_hour = s_tdata[HOUR_LO +: HOUR_W];

	ephb_lockout u_lockout (
		.clk     (clk),
		.ts      (ts_q),
		.last    (last_time_q),
		.lockout (lockout_q),
		.chk     (chk)
	);

	ephb_ram #(
		.WIDTH (BIN_W),
		.DEPTH (DEPTH)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	// The bin read during the evaluate cycle is on rd_data here, together with
	// the registered lockout check. Everything about the item is decided now.
	always_comb begin
		inc        = (rd_data == BIN_MAX) ? rd_data : rd_data + BIN_ONE;
		look_res   = '0;
		look_wr    = 1'b0;
		look_clr   = 1'b0;
		look_acc   = 1'b0;
		look_newhr = 1'b0;
		if (op_q == OP_READ) begin
			look_res.bin_value = rng_q ? rd_data : '0;
		end else if (chk.accepted) begin
			look_acc                 = 1'b1;
			look_res.pulse_accepted  = 1'b1;
			look_res.pulse_period_us = chk.period;
			if (valid_q && rng_q) begin
				look_res.pulse_counted = 1'b1;
				look_newhr             = !(known_q && (prev_hour_q == hour_q));
				look_res.hour_rolled   = look_newhr && known_q;
				look_clr               = look_res.hour_rolled && (prev_hour_q == DAY_END_HOUR);
				look_res.day_cleared   = look_clr;
				look_res.bin_value     = look_clr ? BIN_ONE : inc;
				look_wr                = !look_clr;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (init_cnt_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = ST_LOOK;
			end
			ST_LOOK: begin
				state_d = look_clr ? ST_CLEAR : ST_OUT;
			end
			ST_CLEAR: begin
				if (clr_cnt_q == HOUR_W'(HOURS - 1)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = look_res.bin_value;
		ram_re    = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = init_cnt_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_EVAL: begin
				ram_re = rng_q;
			end
			ST_LOOK: begin
				ram_we = look_wr;
			end
			ST_CLEAR: begin
				// Zero the whole day; the bin of the current hour restarts at one.
				ram_we    = 1'b1;
				ram_waddr = base_q + AW'(clr_cnt_q);
				ram_wdata = (clr_cnt_q == hour_q) ? BIN_ONE : '0;
			end
			ST_OUT: begin
				out_load = !m_tvalid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_cnt_q  <= '0;
			clr_cnt_q   <= '0;
			m_tvalid_q  <= 1'b0;
			last_time_q <= '0;
			prev_hour_q <= '0;
			known_q     <= 1'b0;
			lockout_q   <= LOCKOUT_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				lockout_q <= cfg_data;
			end
			if (state_q == ST_INIT) begin
				init_cnt_q <= init_cnt_q + AW'(1);
			end
			if (state_q == ST_LOOK) begin
				clr_cnt_q <= '0;
				if (look_acc) begin
					last_time_q <= ts_q;
				end
				if (look_newhr) begin
					prev_hour_q <= hour_q;
					known_q     <= 1'b1;
				end
			end
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + HOUR_W'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q    <= op_t'(s_tuser);
			ts_q    <= s_tdata[TS_W-1:0];
			valid_q <= s_tdata[VALID_BIT];
			hour_q  <= in_hour;
			base_q  <= AW'(in_day) * AW'(HOURS);
			idx_q   <= AW'(in_day) * AW'(HOURS) + AW'(in_hour);
			rng_q   <= (32'(in_day) < DAYS) && (32'(in_hour) < HOURS);
		end
		if (state_q == ST_LOOK) begin
			res_q <= look_res;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_W - $bits(res_t))'(0), out_q.day_cleared, out_q.hour_rolled,
		out_q.pulse_period_us, out_q.bin_value, out_q.pulse_counted, out_q.pulse_accepted};

`ifndef SYNTH
	// A pulse is only ever counted after it passed the lockout check.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (!out_q.pulse_counted || out_q.pulse_accepted))
	else $error("counted pulse without acceptance");

	// A midnight clear is a rollover of a counted pulse and leaves its bin at one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_q.day_cleared) |->
		(out_q.hour_rolled && out_q.pulse_counted && out_q.bin_value == BIN_ONE))
	else $error("day clear result inconsistent");

	// The day clear always starts at the first hour of the day.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK && look_clr) |=> (state_q == ST_CLEAR && clr_cnt_q == '0))
	else $error("day clear did not start at hour zero");

	// No item is taken before the bin store has been cleared after reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT) |-> !(s_tvalid && s_tready))
	else $error("item accepted during bin clearing pass");
`endif

endmodule
`default_nettype wire

>>> sv/ephb_ram.sv
`default_nettype none
module ephb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 768
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> sv/ephb_lockout.sv
`default_nettype none
module ephb_lockout (
	input  wire logic                         clk,
	input  wire logic [ephb_pkg::TS_W-1:0]    ts,
	input  wire logic [ephb_pkg::TS_W-1:0]    last,
	input  wire logic [ephb_pkg::LOCK_W-1:0]  lockout,
	output ephb_pkg::chk_t                    chk
);
	import ephb_pkg::*;

	// One extra bit catches time going backwards as a borrow.
	logic [TS_W:0] diff_s1;

	always_ff @(posedge clk) begin
		diff_s1 <= {1'b0, ts} - {1'b0, last};
	end

	always_comb begin
		chk.period   = diff_s1[TS_W-1:0];
		chk.accepted = !diff_s1[TS_W] &&
			((|diff_s1[TS_W-1:LOCK_W]) || (diff_s1[LOCK_W-1:0] >= lockout));
	end

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the hourly pulse binner.
//
// An initial block queues stimulus items (pulse events and bin reads) and
// reprograms the lockout register between phases, each time after every
// expected result has come back. A clocked driver feeds the queued items to
// the slave stream, and a clocked monitor feeds each accepted item to a
// predictor that keeps its own copy of the bin store, the last accepted
// pulse time, the hour tracker and the lockout. Each result on the master
// stream is compared field by field with the oldest prediction.
module tb;
	import ephb_pkg::*;

	localparam int N_BINS       = DAYS_DEF * HOURS_DEF;
	localparam int WATCH_LIMIT  = 5000;
	localparam int LONG_HOLD    = 300;
	localparam int PHASE_ITEMS  = 240;
	localparam int BURST_PULSES = 20;
	localparam logic [TS_W-1:0] TS_MAX = '1;

	// One slave-stream word, lowest field last.
	typedef struct packed {
		logic [IN_W-TS_W-1-DAY_W-HOUR_W-1:0] fill;
		logic [HOUR_W-1:0]                   hour;
		logic [DAY_W-1:0]                    day;
		logic                                valid;
		logic [TS_W-1:0]                     ts;
	} pulse_word_t;

	typedef struct {
		op_t               opc;
		logic [TS_W-1:0]   ts;
		logic              valid;
		logic [DAY_W-1:0]  day;
		logic [HOUR_W-1:0] hour;
	} meter_item_t;

	logic              clk;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata  = '0;
	logic              s_tuser  = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic              cfg_we   = 1'b0;
	logic [LOCK_W-1:0] cfg_data = '0;

	energy_pulse_hourly_binner i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Predictor state: the bin store, the last accepted pulse time, the hour
	// tracker and the lockout as the block should hold them.
	logic [BIN_W-1:0]  hour_bins [N_BINS];
	logic [63:0]       last_stamp;
	logic [HOUR_W-1:0] prev_hour;
	logic              prev_hour_known;
	logic [LOCK_W-1:0] lockout_now;

	res_t        expected_reports [$];
	meter_item_t pending_items [$];

	// Bookkeeping shared by the processes.
	int n_queued   = 0;
	int n_accepted = 0;
	int n_results  = 0;
	int n_errors   = 0;
	int n_reads    = 0;
	int n_rejected = 0;
	int n_passed   = 0;
	int n_binned   = 0;
	int n_rolls    = 0;
	int n_clears   = 0;
	int n_capped   = 0;
	logic idling   = 1'b1;
	logic in_took  = 1'b0;

	// Generator walk: the latest timestamp sent and the wall-clock position.
	logic [TS_W-1:0]   walk_stamp = '0;
	logic [DAY_W-1:0]  walk_day   = '0;
	logic [HOUR_W-1:0] walk_hour  = '0;

	// Works out the result of one accepted item and updates the state.
	function automatic res_t meter_predict(input meter_item_t it);
		res_t        r;
		logic [63:0] span;
		int          idx;
		int          base;
		r = '0;
		span = {1'b0, it.ts} - last_stamp;
		idx = int'(it.day) * HOURS_DEF + int'(it.hour);
		base = int'(it.day) * HOURS_DEF;
		if (it.opc == OP_READ) begin
			n_reads++;
			if (it.hour < HOURS_DEF)
				r.bin_value = hour_bins[idx];
		end else if ({1'b0, it.ts} >= last_stamp && span >= 64'(lockout_now)) begin
			n_passed++;
			r.pulse_accepted = 1'b1;
			r.pulse_period_us = span[TS_W-1:0];
			last_stamp = {1'b0, it.ts};
			// Invalid clock or an hour past 23: only the time moves on.
			if (it.valid && it.hour < HOURS_DEF) begin
				n_binned++;
				r.pulse_counted = 1'b1;
				if (hour_bins[idx] != BIN_MAX)
					hour_bins[idx]++;
				else
					n_capped++;
				if (!(prev_hour_known && prev_hour == it.hour)) begin
					if (prev_hour_known) begin
						n_rolls++;
						r.hour_rolled = 1'b1;
						// Leaving hour 23 starts a new day: wipe its bins.
						if (prev_hour == DAY_END_HOUR) begin
							n_clears++;
							for (int h = 0; h < HOURS_DEF; h++)
								hour_bins[base + h] = '0;
							hour_bins[idx] = BIN_ONE;
							r.day_cleared = 1'b1;
						end
					end
					prev_hour = it.hour;
					prev_hour_known = 1'b1;
				end
				r.bin_value = hour_bins[idx];
			end
		end else begin
			n_rejected++;
		end
		return r;
	endfunction

	task automatic check_field(input string label, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			n_errors++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, label, want, got);
		end
	endtask

	// Driver: a new item goes out at the falling edge once the previous one
	// has been taken, unless an idle burst is running.
	int in_gap = 0;
	always @(negedge clk) begin
		meter_item_t it;
		pulse_word_t w;
		if (arst_n && (!s_tvalid || in_took)) begin
			if (in_gap == 0 && idling && $urandom_range(0, 11) == 0)
				in_gap = $urandom_range(1, 17);
			if (in_gap > 0 || pending_items.size() == 0) begin
				if (in_gap > 0)
					in_gap--;
				s_tvalid <= 1'b0;
			end else begin
				it = pending_items.pop_front();
				w = '0;
				w.ts = it.ts;
				w.valid = it.valid;
				w.day = it.day;
				w.hour = it.hour;
				s_tvalid <= 1'b1;
				s_tdata <= w;
				s_tuser <= it.opc;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off while the sender
	// still has plenty queued, so that the block backs up into its input.
	int   out_gap   = 0;
	int   hold_left = 0;
	logic long_done = 1'b0;
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!long_done && n_results >= 300 && pending_items.size() > 100) begin
			long_done = 1'b1;
			hold_left = LONG_HOLD - 1;
			m_tready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap--;
			m_tready <= 1'b0;
		end else if (idling && $urandom_range(0, 9) == 0) begin
			out_gap = $urandom_range(1, 17) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Monitor: predicts on every accepted input item and checks every
	// accepted result against the oldest prediction.
	always @(posedge clk) begin
		meter_item_t it;
		pulse_word_t w;
		res_t        got;
		res_t        want;
		in_took <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			w = s_tdata;
			it.opc = op_t'(s_tuser);
			it.ts = w.ts;
			it.valid = w.valid;
			it.day = w.day;
			it.hour = w.hour;
			expected_reports.push_back(meter_predict(it));
			n_accepted++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			got = res_t'(m_tdata[$bits(res_t)-1:0]);
			if (expected_reports.size() == 0) begin
				n_errors++;
				$display("%0t: result with no item outstanding, expected none, actual 0x%0h",
					$time, m_tdata);
			end else begin
				want = expected_reports.pop_front();
				check_field("pulse_accepted", 64'(want.pulse_accepted), 64'(got.pulse_accepted));
				check_field("pulse_counted", 64'(want.pulse_counted), 64'(got.pulse_counted));
				check_field("bin_value", 64'(want.bin_value), 64'(got.bin_value));
				check_field("pulse_period_us", 64'(want.pulse_period_us),
					64'(got.pulse_period_us));
				check_field("hour_rolled", 64'(want.hour_rolled), 64'(got.hour_rolled));
				check_field("day_cleared", 64'(want.day_cleared), 64'(got.day_cleared));
				check_field("zero fill", 64'd0, 64'(m_tdata[OUT_W-1:$bits(res_t)]));
			end
		end
	end

	// Watchdog: ends the run when nothing moves on either stream for too long.
	// The clearing pass after reset and the long hold-off fit well inside the
	// limit.
	int quiet = 0;
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet = 0;
		else
			quiet++;
		if (quiet == WATCH_LIMIT) begin
			$display("%0t: no item moved for %0d cycles, %0d results still due",
				$time, WATCH_LIMIT, expected_reports.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic queue_item(input op_t opc, input logic [TS_W-1:0] ts, input logic valid,
			input logic [DAY_W-1:0] day, input logic [HOUR_W-1:0] hour);
		meter_item_t it;
		it.opc = opc;
		it.ts = ts;
		it.valid = valid;
		it.day = day;
		it.hour = hour;
		pending_items.push_back(it);
		n_queued++;
	endtask

	// Waits until every queued item has been taken and answered.
	task automatic drain();
		while (n_accepted != n_queued || expected_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_lockout(input logic [LOCK_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		lockout_now = value;
	endtask

	function automatic logic [TS_W-1:0] random_stamp();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[TS_W-1:0];
	endfunction

	// Next timestamp at least one lockout past the walk, sometimes exactly on it.
	function automatic logic [TS_W-1:0] forward_stamp();
		logic [TS_W-1:0] step;
		step = TS_W'(lockout_now);
		if ($urandom_range(0, 9) != 0)
			step += TS_W'($urandom_range(0, lockout_now / 2 + 50));
		walk_stamp += step;
		return walk_stamp;
	endfunction

	// Mostly well-formed pulse sequences that walk through the hours and days
	// (so rollovers and midnight clears keep happening), some reads, and some
	// noise: invalid clock, bad hours, early and backward timestamps.
	task automatic queue_random(input int count);
		logic [TS_W-1:0]   ts;
		logic [TS_W-1:0]   back;
		int                pick;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				if ($urandom_range(0, 1))
					queue_item(OP_READ, random_stamp(), 1'($urandom), walk_day,
						HOUR_W'($urandom_range(0, HOURS_DEF - 1)));
				else
					queue_item(OP_READ, random_stamp(), 1'($urandom),
						DAY_W'($urandom), HOUR_W'($urandom));
			end else if (pick < 85) begin
				if ($urandom_range(0, 2) == 0) begin
					if (walk_hour == DAY_END_HOUR) begin
						walk_hour = '0;
						walk_day++;
					end else begin
						walk_hour++;
					end
				end
				if ($urandom_range(0, 49) == 0) begin
					walk_day = DAY_W'($urandom);
					walk_hour = HOUR_W'($urandom_range(0, HOURS_DEF - 1));
				end
				queue_item(OP_PULSE, forward_stamp(), 1'b1, walk_day, walk_hour);
			end else begin
				case ($urandom_range(0, 3))
					0: begin
						queue_item(OP_PULSE, forward_stamp(), 1'b0,
							DAY_W'($urandom), HOUR_W'($urandom));
					end
					1: begin
						queue_item(OP_PULSE, forward_stamp(), 1'b1, DAY_W'($urandom),
							HOUR_W'($urandom_range(HOURS_DEF, 31)));
					end
					2: begin
						back = TS_W'($urandom_range(1, lockout_now + 1000));
						ts = (back > walk_stamp) ? '0 : walk_stamp - back;
						queue_item(OP_PULSE, ts, 1'b1, walk_day, walk_hour);
					end
					default: begin
						ts = walk_stamp;
						if (lockout_now != 0)
							ts += TS_W'($urandom_range(0, lockout_now - 1));
						walk_stamp = ts;
						queue_item(OP_PULSE, ts, 1'b1, walk_day, walk_hour);
					end
				endcase
			end
		end
	endtask

	initial begin
		logic [63:0] r;
		for (int i = 0; i < N_BINS; i++)
			hour_bins[i] = '0;
		last_stamp = '0;
		prev_hour = '0;
		prev_hour_known = 1'b0;
		lockout_now = LOCKOUT_RESET;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset lockout of 100000 us: empty read, a pulse
		// at time zero, the lockout boundary on both sides, time going
		// backwards, invalid clock, hours past 23, an hour change, a midnight
		// clear and the day wrap from 31 to 0, then reads of what was left.
		queue_item(OP_READ,  '0,              1'b0, 5'd0,  5'd0);
		queue_item(OP_PULSE, '0,              1'b1, 5'd0,  5'd0);
		queue_item(OP_PULSE, TS_W'(99999),    1'b1, 5'd0,  5'd0);
		queue_item(OP_PULSE, TS_W'(100000),   1'b0, 5'd0,  5'd0);
		queue_item(OP_PULSE, TS_W'(200000),   1'b1, 5'd0,  5'd0);
		queue_item(OP_PULSE, TS_W'(150000),   1'b1, 5'd0,  5'd0);
		queue_item(OP_PULSE, TS_W'(300000),   1'b1, 5'd0,  5'd0);
		queue_item(OP_PULSE, TS_W'(400000),   1'b1, 5'd0,  5'd24);
		queue_item(OP_PULSE, TS_W'(500000),   1'b1, 5'd31, 5'd31);
		queue_item(OP_PULSE, TS_W'(600000),   1'b0, 5'd3,  5'd5);
		queue_item(OP_PULSE, TS_W'(700000),   1'b1, 5'd0,  5'd1);
		queue_item(OP_PULSE, TS_W'(800000),   1'b1, 5'd0,  5'd23);
		queue_item(OP_PULSE, TS_W'(900000),   1'b1, 5'd1,  5'd23);
		queue_item(OP_PULSE, TS_W'(1000000),  1'b1, 5'd1,  5'd0);
		queue_item(OP_READ,  '0,              1'b0, 5'd1,  5'd23);
		queue_item(OP_READ,  '0,              1'b0, 5'd0,  5'd0);
		queue_item(OP_READ,  '0,              1'b0, 5'd0,  5'd24);
		queue_item(OP_READ,  TS_MAX,          1'b1, 5'd31, 5'd31);
		queue_item(OP_READ,  '0,              1'b0, 5'd1,  5'd0);
		queue_item(OP_PULSE, TS_W'(1099999),  1'b1, 5'd1,  5'd0);
		queue_item(OP_PULSE, TS_W'(1200000),  1'b1, 5'd31, 5'd23);
		queue_item(OP_PULSE, TS_W'(1300000),  1'b1, 5'd31, 5'd23);
		queue_item(OP_PULSE, TS_W'(1400000),  1'b1, 5'd0,  5'd0);
		queue_item(OP_READ,  '0,              1'b0, 5'd0,  5'd23);
		walk_stamp = TS_W'(1400000);
		drain();

		// Random phases, each under its own lockout. The sender pauses at
		// every boundary until all results are back. Two forward jumps of
		// the timestamp bring its top bits into play.
		idling = 1'b0;
		write_lockout('0);
		queue_random(PHASE_ITEMS);
		drain();

		idling = 1'b1;
		write_lockout('1);
		queue_random(PHASE_ITEMS);
		drain();

		r = {$urandom, $urandom};
		walk_stamp = {2'b01, r[TS_W-3:0]};
		write_lockout(LOCK_W'($urandom));
		queue_random(PHASE_ITEMS);
		drain();

		idling = 1'b0;
		write_lockout(LOCK_W'($urandom_range(1, 2000)));
		queue_random(PHASE_ITEMS);
		drain();

		idling = 1'b1;
		r = {$urandom, $urandom};
		walk_stamp = {2'b10, r[TS_W-3:0]};
		write_lockout(LOCKOUT_RESET);
		queue_random(PHASE_ITEMS);
		drain();

		// Last part, no idling: a run of pulses into one bin with lockout
		// zero, read it, then the largest timestamp twice (a zero period) and
		// a pulse at time zero that must now be rejected.
		idling = 1'b0;
		write_lockout('0);
		for (int k = 0; k < BURST_PULSES; k++) begin
			walk_stamp += TS_W'($urandom_range(0, 2));
			queue_item(OP_PULSE, walk_stamp, 1'b1, 5'd7, 5'd9);
		end
		queue_item(OP_READ,  '0,     1'b0, 5'd7, 5'd9);
		queue_item(OP_PULSE, TS_MAX, 1'b1, 5'd7, 5'd9);
		queue_item(OP_PULSE, TS_MAX, 1'b1, 5'd7, 5'd9);
		queue_item(OP_PULSE, '0,     1'b1, 5'd7, 5'd9);
		queue_item(OP_READ,  '0,     1'b0, 5'd7, 5'd9);
		drain();

		// Let any stray result show up before the verdict.
		repeat (40) @(posedge clk);

		$display("Ran %0d items: %0d reads, %0d pulses taken, %0d locked out, %0d binned",
			n_accepted, n_reads, n_passed, n_rejected, n_binned);
		$display("Saw %0d hour changes, %0d midnight clears, %0d increments held at the ceiling",
			n_rolls, n_clears, n_capped);
		if (n_errors == 0 && expected_reports.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> files.f
sv/ephb_pkg.sv
sv/ephb_ram.sv
sv/ephb_lockout.sv
sv/energy_pulse_hourly_binner.sv
tb/tb.sv
